### rtl/core/letter_handle_lru_cache_unit_defines.svh
// ----------------------------------------------------------------------------
// letter handle lru cache unit assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LETTER_HANDLE_LRU_CACHE_UNIT_DEFINES_SVH
`define LETTER_HANDLE_LRU_CACHE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define LHLC_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lhlc check failed");
`define LHLC_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("lhlc forbidden condition");
`else
`define LHLC_ASSERT(name, prop)
`define LHLC_NEVER(name, expr)
`endif

`endif

### rtl/core/lhlc_pkg.sv
// ----------------------------------------------------------------------------
// lhlc package
// shared widths, constants, types and the key folding function
// ----------------------------------------------------------------------------
package lhlc_pkg;

   localparam int KEYS    = 256;
   localparam int SLOTS   = 8;
   localparam int KEY_W   = 8;
   localparam int SLOT_W  = 3;
   localparam int CNT_W   = 4;
   localparam int LEN_W   = 16;
   localparam int STAMP_W = 32;
   localparam int TOTAL_W = 24;
   localparam int LIM_W   = 4;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [LIM_W-1:0]   MAX_OPEN_RESET = 4'd6;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX      = {TOTAL_W{1'b1}};

   // register index taken from paddr[2]
   localparam logic REG_MAX_OPEN = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVICT,
      ST_UPDATE
   } state_type;

   function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] b);
      logic [KEY_W-1:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

### rtl/core/lhlc_if.sv
// ----------------------------------------------------------------------------
// lhlc channel interfaces
// valid/ready channels for request words and result words
// ----------------------------------------------------------------------------
interface lhlc_req_if;
   logic                         valid;
   logic                         ready;
   logic [lhlc_pkg::KEY_W-1:0]   key_byte;
   logic [lhlc_pkg::LEN_W-1:0]   write_length;

   modport source (output valid, key_byte, write_length, input ready);
   modport sink   (input valid, key_byte, write_length, output ready);
endinterface

interface lhlc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lhlc_pkg::SLOT_W-1:0]   slot;
   logic                          evicted_valid;
   logic [lhlc_pkg::KEY_W-1:0]    evicted_key;
   logic                          append_open;
   logic [lhlc_pkg::TOTAL_W-1:0]  key_total;

   modport source (output valid, hit, slot, evicted_valid, evicted_key, append_open,
                   key_total, input ready);
   modport sink   (input valid, hit, slot, evicted_valid, evicted_key, append_open,
                   key_total, output ready);
endinterface

### rtl/core/lhlc_ram.sv
// ----------------------------------------------------------------------------
// lhlc generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lhlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/letter_handle_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// letter handle lru cache unit
// maps each word key onto an lru-managed pool of handle slots
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// req_ch    in   valid/ready     key_byte, write_length
// rsp_ch    out  valid/ready     hit, slot, evicted_valid, evicted_key,
//                                append_open, key_total
// csr       in   apb write/read  max_open at byte address 0
//
// a word is accepted, then each slot in turn goes through the shared slot
// compare unit, then the update step runs
// each eviction adds an evict step, and another full scan when a lowered limit
// forces one; byte totals use per-key valid bits, no clearing pass
// the result sits in an output register; the update waits while it is full
// ----------------------------------------------------------------------------
`include "letter_handle_lru_cache_unit_defines.svh"

module letter_handle_lru_cache_unit (
   input  logic                          clock,
   input  logic                          reset,
   lhlc_req_if.sink                      req_ch,
   lhlc_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lhlc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lhlc_pkg::DATA_W-1:0]   pwdata,
   output logic [lhlc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int SLOTS   = lhlc_pkg::SLOTS;
   localparam int KEYS    = lhlc_pkg::KEYS;
   localparam int KEY_W   = lhlc_pkg::KEY_W;
   localparam int SLOT_W  = lhlc_pkg::SLOT_W;
   localparam int CNT_W   = lhlc_pkg::CNT_W;
   localparam int LEN_W   = lhlc_pkg::LEN_W;
   localparam int STAMP_W = lhlc_pkg::STAMP_W;
   localparam int TOTAL_W = lhlc_pkg::TOTAL_W;
   localparam int LIM_W   = lhlc_pkg::LIM_W;

   lhlc_pkg::state_type state_ff, state_in;

   logic [LIM_W-1:0]   max_open_ff;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [SLOT_W-1:0]  scan_idx_ff, scan_idx_in;

   logic               hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]  hit_slot_ff, hit_slot_in;
   logic               old_found_ff, old_found_in;
   logic [SLOT_W-1:0]  old_slot_ff, old_slot_in;
   logic [STAMP_W-1:0] old_stamp_ff, old_stamp_in;
   logic [KEY_W-1:0]   old_key_ff, old_key_in;
   logic               free_found_ff, free_found_in;
   logic [SLOT_W-1:0]  free_slot_ff, free_slot_in;
   logic               ev_valid_ff, ev_valid_in;
   logic [KEY_W-1:0]   ev_key_ff, ev_key_in;

   logic [SLOTS-1:0]   slot_busy_ff, slot_busy_in;
   logic [KEY_W-1:0]   slot_key_ff [SLOTS];
   logic [KEY_W-1:0]   slot_key_in [SLOTS];
   logic [STAMP_W-1:0] slot_stamp_ff [SLOTS];
   logic [STAMP_W-1:0] slot_stamp_in [SLOTS];
   logic [CNT_W-1:0]   open_count_ff, open_count_in;
   logic [STAMP_W-1:0] use_counter_ff, use_counter_in;
   logic [KEYS-1:0]    bytes_valid_ff, bytes_valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [KEY_W-1:0]   rsp_ev_key_ff, rsp_ev_key_in;
   logic               rsp_app_ff, rsp_app_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic               req_accept;
   logic               out_free;
   logic [LIM_W-1:0]   lim;
   logic               scan_last;
   logic               cur_busy;
   logic [KEY_W-1:0]   cur_key;
   logic [STAMP_W-1:0] cur_stamp;
   logic               is_hit;
   logic               is_older;
   logic               is_free;
   logic [CNT_W-1:0]   open_dec;
   logic               hit_now;
   logic [SLOT_W-1:0]  slot_sel;
   logic [STAMP_W-1:0] stamp_next;
   logic [TOTAL_W-1:0] old_bytes;
   logic [TOTAL_W:0]   sum_wide;
   logic [TOTAL_W-1:0] sum_sat;
   logic [TOTAL_W-1:0] bytes_rd;
   logic               bytes_wr;

   // configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_open_ff <= lhlc_pkg::MAX_OPEN_RESET;
      end else if (psel && penable && pwrite && paddr[2] == lhlc_pkg::REG_MAX_OPEN) begin
         max_open_ff <= pwdata[LIM_W-1:0];
      end
   end

   assign prdata = (paddr[2] == lhlc_pkg::REG_MAX_OPEN) ?
                   {{(lhlc_pkg::DATA_W-LIM_W){1'b0}}, max_open_ff} : '0;

   always_comb begin
      if (max_open_ff == '0) begin
         lim = LIM_W'(1);
      end else if (max_open_ff > LIM_W'(SLOTS)) begin
         lim = LIM_W'(SLOTS);
      end else begin
         lim = max_open_ff;
      end
   end

   // shared slot compare unit
   assign req_accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == lhlc_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign scan_last = (scan_idx_ff == SLOT_W'(SLOTS - 1));

   assign cur_busy  = slot_busy_ff[scan_idx_ff];
   assign cur_key   = slot_key_ff[scan_idx_ff];
   assign cur_stamp = slot_stamp_ff[scan_idx_ff];

   assign is_hit   = cur_busy && (cur_key == key_ff);
   assign is_older = cur_busy && (!old_found_ff || cur_stamp < old_stamp_ff ||
                     (cur_stamp == old_stamp_ff && cur_key < old_key_ff));
   assign is_free  = !cur_busy && !free_found_ff &&
                     ({{(LIM_W-SLOT_W){1'b0}}, scan_idx_ff} < lim);

   assign open_dec = open_count_ff - CNT_W'(1);

   // update datapath
   assign hit_now    = hit_found_ff;
   assign slot_sel   = hit_now ? hit_slot_ff : (free_found_ff ? free_slot_ff : '0);
   assign stamp_next = use_counter_ff + STAMP_W'(1);
   assign old_bytes  = bytes_valid_ff[key_ff] ? bytes_rd : '0;
   assign sum_wide   = {1'b0, old_bytes} + (TOTAL_W+1)'(len_ff);
   assign sum_sat    = sum_wide[TOTAL_W] ? lhlc_pkg::TOTAL_MAX : sum_wide[TOTAL_W-1:0];
   assign bytes_wr   = (state_ff == lhlc_pkg::ST_UPDATE) && out_free;

   lhlc_ram #(
      .WIDTH (TOTAL_W),
      .DEPTH (KEYS)
   ) u_bytes_ram (
      .clock   (clock),
      .wr_en   (bytes_wr),
      .wr_addr (key_ff),
      .wr_data (sum_sat),
      .rd_en   (req_accept),
      .rd_addr (lhlc_pkg::fold_key(req_ch.key_byte)),
      .rd_data (bytes_rd)
   );

   // sequencer
   always_comb begin
      state_in        = state_ff;
      key_in          = key_ff;
      len_in          = len_ff;
      scan_idx_in     = scan_idx_ff;
      hit_found_in    = hit_found_ff;
      hit_slot_in     = hit_slot_ff;
      old_found_in    = old_found_ff;
      old_slot_in     = old_slot_ff;
      old_stamp_in    = old_stamp_ff;
      old_key_in      = old_key_ff;
      free_found_in   = free_found_ff;
      free_slot_in    = free_slot_ff;
      ev_valid_in     = ev_valid_ff;
      ev_key_in       = ev_key_ff;
      slot_busy_in    = slot_busy_ff;
      slot_key_in     = slot_key_ff;
      slot_stamp_in   = slot_stamp_ff;
      open_count_in   = open_count_ff;
      use_counter_in  = use_counter_ff;
      bytes_valid_in  = bytes_valid_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_key_in   = rsp_ev_key_ff;
      rsp_app_in      = rsp_app_ff;
      rsp_total_in    = rsp_total_ff;

      unique case (state_ff)
         lhlc_pkg::ST_IDLE: begin
            if (req_accept) begin
               key_in        = lhlc_pkg::fold_key(req_ch.key_byte);
               len_in        = req_ch.write_length;
               scan_idx_in   = '0;
               hit_found_in  = 1'b0;
               old_found_in  = 1'b0;
               free_found_in = 1'b0;
               ev_valid_in   = 1'b0;
               ev_key_in     = '0;
               state_in      = lhlc_pkg::ST_SCAN;
            end
         end
         lhlc_pkg::ST_SCAN: begin
            if (is_hit) begin
               hit_found_in = 1'b1;
               hit_slot_in  = scan_idx_ff;
            end
            if (is_older) begin
               old_found_in = 1'b1;
               old_slot_in  = scan_idx_ff;
               old_stamp_in = cur_stamp;
               old_key_in   = cur_key;
            end
            if (is_free) begin
               free_found_in = 1'b1;
               free_slot_in  = scan_idx_ff;
            end
            scan_idx_in = scan_idx_ff + SLOT_W'(1);
            if (scan_last) begin
               if (hit_found_ff || is_hit) begin
                  state_in = lhlc_pkg::ST_UPDATE;
               end else if (open_count_ff >= lim) begin
                  state_in = lhlc_pkg::ST_EVICT;
               end else begin
                  state_in = lhlc_pkg::ST_UPDATE;
               end
            end
         end
         lhlc_pkg::ST_EVICT: begin
            slot_busy_in[old_slot_ff] = 1'b0;
            open_count_in             = open_dec;
            ev_valid_in               = 1'b1;
            ev_key_in                 = old_key_ff;
            if (open_dec >= lim) begin
               scan_idx_in   = '0;
               old_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = lhlc_pkg::ST_SCAN;
            end else begin
               if ({{(LIM_W-SLOT_W){1'b0}}, old_slot_ff} < lim &&
                   (!free_found_ff || old_slot_ff < free_slot_ff)) begin
                  free_found_in = 1'b1;
                  free_slot_in  = old_slot_ff;
               end
               state_in = lhlc_pkg::ST_UPDATE;
            end
         end
         lhlc_pkg::ST_UPDATE: begin
            if (out_free) begin
               slot_busy_in[slot_sel]  = 1'b1;
               slot_key_in[slot_sel]   = key_ff;
               slot_stamp_in[slot_sel] = stamp_next;
               use_counter_in          = stamp_next;
               bytes_valid_in[key_ff]  = 1'b1;
               if (!hit_now) begin
                  open_count_in = open_count_ff + CNT_W'(1);
               end
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = hit_now;
               rsp_slot_in     = slot_sel;
               rsp_ev_valid_in = ev_valid_ff;
               rsp_ev_key_in   = ev_key_ff;
               rsp_app_in      = !hit_now && (old_bytes != '0);
               rsp_total_in    = sum_sat;
               state_in        = lhlc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lhlc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lhlc_pkg::ST_IDLE;
         slot_busy_ff   <= '0;
         open_count_ff  <= '0;
         use_counter_ff <= '0;
         bytes_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_busy_ff   <= slot_busy_in;
         open_count_ff  <= open_count_in;
         use_counter_ff <= use_counter_in;
         bytes_valid_ff <= bytes_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      len_ff          <= len_in;
      scan_idx_ff     <= scan_idx_in;
      hit_found_ff    <= hit_found_in;
      hit_slot_ff     <= hit_slot_in;
      old_found_ff    <= old_found_in;
      old_slot_ff     <= old_slot_in;
      old_stamp_ff    <= old_stamp_in;
      old_key_ff      <= old_key_in;
      free_found_ff   <= free_found_in;
      free_slot_ff    <= free_slot_in;
      ev_valid_ff     <= ev_valid_in;
      ev_key_ff       <= ev_key_in;
      slot_key_ff     <= slot_key_in;
      slot_stamp_ff   <= slot_stamp_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_key_ff   <= rsp_ev_key_in;
      rsp_app_ff      <= rsp_app_in;
      rsp_total_ff    <= rsp_total_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.evicted_valid = rsp_ev_valid_ff;
   assign rsp_ch.evicted_key   = rsp_ev_key_ff;
   assign rsp_ch.append_open   = rsp_app_ff;
   assign rsp_ch.key_total     = rsp_total_ff;

   // checks
   `LHLC_ASSERT(a_open_bound, open_count_ff <= CNT_W'(SLOTS))
   `LHLC_ASSERT(a_count_match, open_count_ff == CNT_W'($countones(slot_busy_ff)))
   `LHLC_ASSERT(a_update_done, (state_ff == lhlc_pkg::ST_UPDATE && out_free) |=> (state_ff == lhlc_pkg::ST_IDLE && rsp_valid_ff))
   `LHLC_NEVER(a_hit_no_evict, rsp_valid_ff && rsp_hit_ff && rsp_ev_valid_ff)

endmodule

### verif/letter_handle_lru_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// letter handle lru cache unit testbench
// drives request words under several idle patterns and max_open settings,
// predicts hit, slot, eviction, open mode and saturating byte totals with an
// in-bench lru model and checks every result word in order; max_open writes
// are read back over the apb port
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module letter_handle_lru_cache_unit_tb;
   import lhlc_pkg::*;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               ev_valid;
      logic [KEY_W-1:0]   ev_key;
      logic               append;
      logic [TOTAL_W-1:0] total;
   } lookup_type;

   localparam logic [ADDR_W-1:0] MAX_OPEN_ADDR = {REG_MAX_OPEN, 2'b00};

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   lhlc_req_if req_ch ();
   lhlc_rsp_if rsp_ch ();

   letter_handle_lru_cache_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // lru model state
   logic [LIM_W-1:0]   limit_reg;
   logic               open_flag  [KEYS];
   logic [SLOT_W-1:0]  held_slot  [KEYS];
   logic [31:0]        last_use   [KEYS];
   logic [TOTAL_W-1:0] byte_total [KEYS];
   logic               slot_taken [SLOTS];
   logic [31:0]        use_count;
   int                 open_total;

   lookup_type  lookup_q[$];
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned error_count;
   int unsigned words_sent;
   int unsigned hits_seen;
   int unsigned evictions_seen;
   int unsigned limit_writes;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic lookup_type predict_lookup(input logic [KEY_W-1:0] kb,
                                                 input logic [LEN_W-1:0] len);
      lookup_type       r;
      logic [KEY_W-1:0] key;
      int               lim;
      int               victim;
      logic [31:0]      best;
      int               s;
      logic             found;
      logic [TOTAL_W:0] sum;
      r = '0;
      key = (kb >= 8'h41 && kb <= 8'h5A) ? kb + 8'h20 : kb;
      lim = (limit_reg == 0) ? 1 : ((limit_reg > SLOTS) ? SLOTS : int'(limit_reg));
      if (open_flag[key]) begin
         r.hit = 1'b1;
      end else begin
         // close the oldest keys until there is room, lowest key on a tie
         while (open_total >= lim) begin
            victim = -1;
            best = '0;
            for (int k = 0; k < KEYS; k++) begin
               if (open_flag[k] && (victim < 0 || last_use[k] < best)) begin
                  best = last_use[k];
                  victim = k;
               end
            end
            if (victim < 0) begin
               open_total = 0;
            end else begin
               slot_taken[held_slot[victim]] = 1'b0;
               open_flag[victim] = 1'b0;
               open_total--;
               r.ev_valid = 1'b1;
               r.ev_key = victim[KEY_W-1:0];
            end
         end
         found = 1'b0;
         s = 0;
         for (int i = 0; i < lim; i++) begin
            if (!found && !slot_taken[i]) begin
               found = 1'b1;
               s = i;
            end
         end
         slot_taken[s] = 1'b1;
         held_slot[key] = s[SLOT_W-1:0];
         open_flag[key] = 1'b1;
         open_total++;
         r.append = (byte_total[key] != '0);
      end
      use_count++;
      last_use[key] = use_count;
      sum = {1'b0, byte_total[key]} + {{(TOTAL_W+1-LEN_W){1'b0}}, len};
      if (sum > {1'b0, TOTAL_MAX}) begin
         sum = {1'b0, TOTAL_MAX};
      end
      byte_total[key] = sum[TOTAL_W-1:0];
      r.slot = held_slot[key];
      r.total = sum[TOTAL_W-1:0];
      return r;
   endfunction

   function automatic string fmt_lookup(input lookup_type r);
      return $sformatf("hit %0d slot %0d evicted %0d/%02h append %0d total %0d",
                       r.hit, r.slot, r.ev_valid, r.ev_key, r.append, r.total);
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      lookup_type want;
      lookup_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.hit, rsp_ch.slot, rsp_ch.evicted_valid, rsp_ch.evicted_key,
                 rsp_ch.append_open, rsp_ch.key_total};
         if (lookup_q.size() == 0) begin
            note_error({"unexpected word: ", fmt_lookup(got)});
         end else begin
            want = lookup_q.pop_front();
            if (got !== want) begin
               note_error({"expected ", fmt_lookup(want), ", got ", fmt_lookup(got)});
            end
         end
      end
   end

   task automatic send_word(input logic [KEY_W-1:0] kb, input logic [LEN_W-1:0] len);
      lookup_type want;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.key_byte     <= kb;
      req_ch.write_length <= len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      want = predict_lookup(kb, len);
      lookup_q.push_back(want);
      words_sent++;
      if (want.hit) hits_seen++;
      if (want.ev_valid) evictions_seen++;
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (lookup_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic check_limit_reg(input logic [LIM_W-1:0] v);
      logic [DATA_W-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= MAX_OPEN_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== DATA_W'(v)) begin
         note_error($sformatf("max_open read expected %0d, got %0h", v, got));
      end
   endtask

   task automatic write_max_open(input logic [LIM_W-1:0] v);
      drain_words();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MAX_OPEN_ADDR;
      pwdata  <= DATA_W'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      limit_reg = v;
      limit_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_limit_reg(v);
   endtask

   task automatic test_reset_value();
      check_limit_reg(MAX_OPEN_RESET);
   endtask

   // case folding, key and length extremes, first evictions at the reset limit
   task automatic test_directed_words();
      logic [KEY_W-1:0] keys [12];
      logic [LEN_W-1:0] lens [12];
      keys = '{8'h41, 8'h61, 8'h00, 8'hFF, 8'h40, 8'h5B, 8'h5A, 8'h41, 8'h7A, 8'h60,
               8'h7B, 8'h00};
      lens = '{16'd0, 16'd5, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'd7, 16'd9, 16'hFFFF,
               16'd0, 16'd4, 16'd1};
      for (int i = 0; i < 12; i++) begin
         send_word(keys[i], lens[i]);
      end
   endtask

   // limits of one and eight, and the out of range values 0 and 15
   task automatic test_limit_extremes();
      write_max_open(4'd1);
      send_word(8'h62, 16'd1);
      send_word(8'h63, 16'd2);
      send_word(8'h42, 16'd3);
      write_max_open(4'd0);
      send_word(8'h64, 16'd4);
      send_word(8'h44, 16'd5);
      send_word(8'h65, 16'd6);
      write_max_open(4'd8);
      for (int i = 0; i < 9; i++) begin
         send_word(KEY_W'(8'h66 + i), 16'(i));
      end
      write_max_open(4'd15);
      send_word(8'h6F, 16'd1);
      send_word(8'h70, 16'd2);
      send_word(8'h71, 16'd3);
   endtask

   // limit lowered with all slots busy; a key in a high slot keeps it
   task automatic test_limit_lowered();
      write_max_open(4'd8);
      for (int i = 0; i < 8; i++) begin
         send_word(KEY_W'(8'h80 + i), 16'd10);
      end
      send_word(8'h87, 16'd1);
      write_max_open(4'd2);
      send_word(8'h87, 16'd1);
      send_word(8'h90, 16'd2);
      send_word(8'h87, 16'd3);
      send_word(8'h91, 16'd4);
      send_word(8'h80, 16'd5);
   endtask

   task automatic test_total_saturation();
      send_idle_pct = 31;
      recv_stall_pct = 31;
      write_max_open(4'd3);
      for (int i = 0; i < 262; i++) begin
         send_word((i % 2 == 0) ? 8'h73 : 8'h53, 16'hFFFF);
         if (i % 40 == 0) begin
            send_word(KEY_W'(8'h74 + (i % 3)), 16'($urandom_range(0, 65535)));
         end
      end
   endtask

   task automatic test_random_traffic();
      int unsigned idle_set  [4];
      int unsigned stall_set [4];
      logic [LIM_W-1:0] limits [12];
      logic [KEY_W-1:0] edge_keys [10];
      int unsigned ws;
      int unsigned pick;
      logic [KEY_W-1:0] kb;
      logic [LEN_W-1:0] len;
      idle_set  = '{0, 45, 0, 31};
      stall_set = '{0, 0, 45, 31};
      limits = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd6, 4'd0, 4'd2, 4'd8, 4'd5, 4'd1, 4'd7, 4'd3};
      edge_keys = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_set[ph];
         recv_stall_pct = stall_set[ph];
         for (int seg = 0; seg < 3; seg++) begin
            write_max_open(limits[ph * 3 + seg]);
            ws = $urandom_range(2, 12);
            for (int n = 0; n < 62; n++) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) begin
                  kb = 8'($urandom_range(0, ws - 1)) + (($urandom_range(0, 1) != 0) ?
                       8'h61 : 8'h41);
               end else if (pick < 90) begin
                  kb = 8'($urandom_range(0, 255));
               end else begin
                  kb = edge_keys[$urandom_range(0, 9)];
               end
               pick = $urandom_range(0, 99);
               if (pick < 60) begin
                  len = 16'($urandom_range(0, 64));
               end else if (pick < 90) begin
                  len = 16'($urandom_range(0, 65535));
               end else begin
                  len = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
               end
               send_word(kb, len);
            end
         end
      end
   endtask

   task automatic finish_run();
      drain_words();
      repeat (20) @(posedge clock);
      $display("sent %0d words: %0d hits, %0d with evictions", words_sent, hits_seen,
               evictions_seen);
      $display("%0d max_open writes, idle and stall phases 0/0, 45/0, 0/45, 31/31",
               limit_writes);
      if (error_count == 0 && lookup_q.size() == 0) begin
         $display("letter_handle_lru_cache_unit_tb OK");
      end else begin
         $display("letter_handle_lru_cache_unit_tb NOT OK");
      end
      $finish;
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.key_byte = '0;
      req_ch.write_length = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      error_count = 0;
      words_sent = 0;
      hits_seen = 0;
      evictions_seen = 0;
      limit_writes = 0;
      limit_reg = MAX_OPEN_RESET;
      use_count = '0;
      open_total = 0;
      for (int k = 0; k < KEYS; k++) begin
         open_flag[k] = 1'b0;
         held_slot[k] = '0;
         last_use[k] = '0;
         byte_total[k] = '0;
      end
      for (int s = 0; s < SLOTS; s++) begin
         slot_taken[s] = 1'b0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_value();
      test_directed_words();
      test_limit_extremes();
      test_limit_lowered();
      test_total_saturation();
      test_random_traffic();
      finish_run();
   end

   initial begin
      #2000000;
      $display("letter_handle_lru_cache_unit_tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lhlc_pkg.sv
rtl/core/lhlc_if.sv
rtl/core/lhlc_ram.sv
rtl/core/letter_handle_lru_cache_unit.sv
verif/letter_handle_lru_cache_unit_tb.sv
